// ===== hw/rtl/jvs_pkg.sv =====
// Shared types and constants for the JSON-with-comments value end scanner.
package jvs_pkg;

    // Field widths and saturation limits
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned DEPTH_W = 8;

    localparam logic [POS_W-1:0]   MAX_TEXT_LENGTH = {POS_W{1'b1}};
    localparam logic [DEPTH_W-1:0] MAX_NESTING     = {DEPTH_W{1'b1}};

    // Character codes the lexer reacts to
    localparam logic [BYTE_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR      = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LBRACE    = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE    = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_LBRACKET  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACKET  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_COMMA     = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;

    // Lexer modes
    typedef enum logic [2:0] {
        MODE_DONE   = 3'd0,
        MODE_CODE   = 3'd1,
        MODE_SLASH  = 3'd2,
        MODE_LINE   = 3'd3,
        MODE_BLOCK  = 3'd4,
        MODE_STAR   = 3'd5,
        MODE_STRING = 3'd6,
        MODE_ESCAPE = 3'd7
    } lex_mode_t;

    // Scan state carried between items
    typedef struct packed {
        lex_mode_t          mode;
        logic [DEPTH_W-1:0] depth;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   last_end;
    } scan_state_t;

    // One lexer step: updated state plus result flags
    typedef struct packed {
        scan_state_t state;
        logic        emit;
        logic        ended_by_text_end;
    } scan_step_t;

endpackage

// ===== hw/rtl/jsonc_value_end_scanner_core.sv =====
// Top level of the JSON-with-comments value end scanner: registers and handshakes.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_text_byte, s_scan_begin, s_text_final
//   m_      | out       | m_valid / m_ready  | m_value_length, m_ended_by_text_end
//
// An accepted byte is held in the input register; the lexer step then
// updates the scan state and, on a stop or the final byte, loads the result register.
// One byte per cycle while m_ready is high; m_valid is registered, set when the lexer step emits a result.
// A held result stalls the input register, and s_ready drops once that register is full.
// Synchronous active-low reset leaves the scan idle until a byte marks a scan start.
module jsonc_value_end_scanner_core
    import jvs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_text_byte,
    input  logic              s_scan_begin,
    input  logic              s_text_final,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [POS_W-1:0]  m_value_length,
    output logic              m_ended_by_text_end
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_begin_reg;
    logic              in_final_reg;
    scan_state_t       state_reg;
    logic              out_valid_reg;
    logic [POS_W-1:0]  out_length_reg;
    logic              out_text_end_reg;
    scan_step_t        step;
    logic              advance;

    // input register moves on whenever the result slot can take a result
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    jvs_lexer u_lexer (
        .cur        (state_reg),
        .text_byte  (in_byte_reg),
        .scan_begin (in_begin_reg),
        .text_final (in_final_reg),
        .step       (step)
    );

    // control and scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            state_reg.mode     <= MODE_DONE;
            state_reg.depth    <= '0;
            state_reg.pos      <= '0;
            state_reg.last_end <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                state_reg <= step.state;
            end
            if (advance && step.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg  <= s_text_byte;
            in_begin_reg <= s_scan_begin;
            in_final_reg <= s_text_final;
        end
        if (advance && step.emit) begin
            out_length_reg   <= step.state.last_end;
            out_text_end_reg <= step.ended_by_text_end;
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_value_length      = out_length_reg;
    assign m_ended_by_text_end = out_text_end_reg;

endmodule

// ===== hw/rtl/jvs_lexer.sv =====
// Combinational lexer step: one text byte against the current scan state.
module jvs_lexer
    import jvs_pkg::*;
(
    input  scan_state_t       cur,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              scan_begin,
    input  logic              text_final,
    output scan_step_t        step
);

    scan_state_t       base;
    logic [POS_W-1:0]  next_pos;
    logic              run_code;
    logic [POS_W-1:0]  code_last;
    logic              stop;
    scan_state_t       upd;

    always_comb begin
        // scan start drops the running scan
        if (scan_begin) begin
            base.mode     = MODE_CODE;
            base.depth    = '0;
            base.pos      = '0;
            base.last_end = '0;
        end else begin
            base = cur;
        end

        next_pos = (base.pos != MAX_TEXT_LENGTH) ? base.pos + POS_W'(1) : base.pos;

        // plain-text handling, also for the byte after a lone slash
        run_code  = (base.mode == MODE_CODE) ||
                    (base.mode == MODE_SLASH && !(text_byte inside {CH_SLASH, CH_STAR}));
        code_last = (base.mode == MODE_SLASH) ? base.pos : base.last_end;

        upd      = base;
        stop     = 1'b0;
        upd.pos  = next_pos;

        if (run_code) begin
            upd.mode     = MODE_CODE;
            upd.last_end = code_last;
            if (text_byte == CH_SLASH) begin
                upd.mode = MODE_SLASH;
            end else if (text_byte == CH_QUOTE) begin
                upd.mode = MODE_STRING;
            end else if (text_byte inside {CH_LBRACE, CH_LBRACKET}) begin
                if (base.depth != MAX_NESTING) begin
                    upd.depth = base.depth + DEPTH_W'(1);
                end
                upd.last_end = next_pos;
            end else if (text_byte inside {CH_RBRACE, CH_RBRACKET}) begin
                if (base.depth == '0) begin
                    stop = 1'b1;
                end else begin
                    upd.depth    = base.depth - DEPTH_W'(1);
                    upd.last_end = next_pos;
                end
            end else if (text_byte == CH_COMMA && base.depth == '0) begin
                stop = 1'b1;
            end else if (!(text_byte inside {CH_SPACE, CH_TAB, CH_CR, CH_LF})) begin
                upd.last_end = next_pos;
            end
        end else begin
            case (base.mode)
                MODE_SLASH: begin
                    upd.mode = (text_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                end
                MODE_LINE: begin
                    if (text_byte == CH_LF) upd.mode = MODE_CODE;
                end
                MODE_BLOCK: begin
                    if (text_byte == CH_STAR) upd.mode = MODE_STAR;
                end
                MODE_STAR: begin
                    if (text_byte == CH_SLASH) begin
                        upd.mode = MODE_CODE;
                    end else if (text_byte != CH_STAR) begin
                        upd.mode = MODE_BLOCK;
                    end
                end
                MODE_STRING: begin
                    if (text_byte == CH_BACKSLASH) begin
                        upd.mode = MODE_ESCAPE;
                    end else if (text_byte == CH_QUOTE) begin
                        upd.mode     = MODE_CODE;
                        upd.last_end = next_pos;
                    end
                end
                MODE_ESCAPE: begin
                    upd.mode = MODE_STRING;
                end
                default: begin
                    upd = base;
                end
            endcase
        end

        // result on a stop byte or at text end
        step.emit              = 1'b0;
        step.ended_by_text_end = 1'b0;
        if (base.mode == MODE_DONE) begin
            step.state = cur;
        end else if (stop) begin
            upd.mode   = MODE_DONE;
            step.state = upd;
            step.emit  = 1'b1;
        end else if (text_final) begin
            // open slash, string or escape counts up to the text end
            if (upd.mode inside {MODE_SLASH, MODE_STRING, MODE_ESCAPE}) begin
                upd.last_end = next_pos;
            end
            upd.mode               = MODE_DONE;
            step.state             = upd;
            step.emit              = 1'b1;
            step.ended_by_text_end = 1'b1;
        end else begin
            step.state = upd;
        end
    end

endmodule
